>>> design/stk_pkg.sv
// ----------------------------------------------------------------------------
// Streaming top-k selector package
// Shared widths, register map, entry and control types, and FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package stk_pkg;

  localparam int SCORE_W      = 32;
  localparam int IDX_W        = 12;
  localparam int KEEP_W       = 5;
  localparam int MAX_KEEP_DEF = 20;
  localparam int MAX_CAND_DEF = 4096;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(20);

  // Configuration port: one 32-bit register per word.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-3:0] REG_KEEP_COUNT = '0;

  typedef struct packed {
    logic [IDX_W-1:0]          idx;
    logic signed [SCORE_W-1:0] score;
  } stk_entry_t;

  typedef struct packed {
    logic load;
    logic pop;
  } stk_cell_ctrl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } stk_state_t;

endpackage

`default_nettype wire

>>> design/stk_ifaces.sv
// ----------------------------------------------------------------------------
// Streaming top-k selector channels
// Valid/ready channels for candidate scores and ranked results.
// ----------------------------------------------------------------------------
`default_nettype none

interface stk_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [stk_pkg::SCORE_W-1:0] score;
  logic                               final_item;

  modport source (output valid, output score, output final_item, input ready);
  modport sink   (input valid, input score, input final_item, output ready);
endinterface

interface stk_out_if;
  logic                               valid;
  logic                               ready;
  logic [stk_pkg::IDX_W-1:0]          candidate_index;
  logic signed [stk_pkg::SCORE_W-1:0] ranked_score;
  logic                               last_result;

  modport source (output valid, output candidate_index, output ranked_score,
                  output last_result, input ready);
  modport sink   (input valid, input candidate_index, input ranked_score,
                  input last_result, output ready);
endinterface

`default_nettype wire

>>> design/stk_cfg_regs.sv
// ----------------------------------------------------------------------------
// Streaming top-k selector configuration registers
// APB-style register file holding the keep count.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [stk_pkg::CFG_AW-1:0] paddr,
  input  wire logic [stk_pkg::CFG_DW-1:0] pwdata,
  output logic      [stk_pkg::CFG_DW-1:0] prdata,
  output logic                            pready,
  output logic      [stk_pkg::KEEP_W-1:0] keep_count
);
  import stk_pkg::*;

  logic [KEEP_W-1:0] keep_r;
  logic [KEEP_W-1:0] keep_nxt;
  logic              wr_en;

  assign pready     = 1'b1;
  assign wr_en      = psel && penable && pwrite;
  assign keep_count = keep_r;

  always_comb begin
    keep_nxt = keep_r;
    prdata   = '0;
    unique case (paddr[CFG_AW-1:2])
      REG_KEEP_COUNT: begin
        prdata = CFG_DW'(keep_r);
        if (wr_en) begin
          keep_nxt = pwdata[KEEP_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= KEEP_RESET;
    end else begin
      keep_r <= keep_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/stk_cell.sv
// ----------------------------------------------------------------------------
// Streaming top-k selector rank cell
// Holds one ranked entry; inserts, shifts down on insertion, shifts up on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_cell (
  input  wire logic                    clk,
  input  wire stk_pkg::stk_cell_ctrl_t ctrl,
  input  wire stk_pkg::stk_entry_t     new_entry,
  input  wire logic                    occ,
  input  wire logic                    prev_ge,
  input  wire stk_pkg::stk_entry_t     prev_entry,
  input  wire stk_pkg::stk_entry_t     next_entry,
  output stk_pkg::stk_entry_t          entry,
  output logic                         ge
);
  import stk_pkg::*;

  stk_entry_t entry_r;
  stk_entry_t entry_nxt;

  // An occupied entry at least as large as the new score stays ahead of it.
  assign ge    = occ && (entry_r.score >= new_entry.score);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.pop) begin
      entry_nxt = next_entry;
    end else if (ctrl.load && !ge) begin
      entry_nxt = prev_ge ? new_entry : prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

>>> design/streaming_top_k_selector.sv
// ----------------------------------------------------------------------------
// Streaming top-k selector
// Keeps the best keep_count scores of a stream in a chain of rank cells and
// reports them in rank order after the item marked final.
//
//   Channel   Dir  Handshake        Carries
//   in_ch     in   valid/ready      score, final_item
//   out_ch    out  valid/ready      candidate_index, ranked_score, last_result
//   APB       in   psel/penable     keep_count register at byte address 0
//
// While collecting, one score is taken every cycle; every cell compares it
// against its own entry in the same cycle.
// After the final item, results leave one per cycle, unless out_ch stalls,
// from the head cell while the chain shifts up; no scores are taken until the
// last result is taken. A stalled out_ch holds the result; reset clears the
// fill count, position and state, not the cell contents.
// ----------------------------------------------------------------------------
`default_nettype none

module streaming_top_k_selector #(
  parameter int MAX_KEEP       = stk_pkg::MAX_KEEP_DEF,
  parameter int MAX_CANDIDATES = stk_pkg::MAX_CAND_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  stk_in_if.sink                          in_ch,
  stk_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [stk_pkg::CFG_AW-1:0] paddr,
  input  wire logic [stk_pkg::CFG_DW-1:0] pwdata,
  output logic      [stk_pkg::CFG_DW-1:0] prdata,
  output logic                            pready
);
  import stk_pkg::*;

  localparam int KW = $clog2(MAX_KEEP + 1);
  localparam int PW = $clog2(MAX_CANDIDATES + 1);

  stk_state_t        state_r, state_nxt;
  logic [KW-1:0]     filled_r, filled_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [KEEP_W-1:0] keep_count;
  logic [KW-1:0]     keff;
  logic [KW-1:0]     fill_eff;
  logic [KW-1:0]     fill_after;
  logic              in_accept;
  logic              out_accept;
  logic              rank_ok;
  stk_cell_ctrl_t    ctrl;
  stk_entry_t        new_entry;
  stk_entry_t        ent [MAX_KEEP];
  logic              ge  [MAX_KEEP];
  logic              occ [MAX_KEEP];

  stk_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .keep_count(keep_count)
  );

  // Keep count clamped to 1..MAX_KEEP.
  always_comb begin
    if (keep_count == '0) begin
      keff = KW'(1);
    end else if (int'(keep_count) > MAX_KEEP) begin
      keff = KW'(MAX_KEEP);
    end else begin
      keff = KW'(keep_count);
    end
  end

  // Entries ranked beyond a lowered keep count are dropped.
  assign fill_eff   = (filled_r > keff) ? keff : filled_r;
  assign rank_ok    = pos_r < PW'(MAX_CANDIDATES);
  assign in_accept  = in_ch.valid && in_ch.ready;
  assign out_accept = out_ch.valid && out_ch.ready;

  always_comb begin
    fill_after = fill_eff;
    if (ctrl.load && (fill_eff < keff)) begin
      fill_after = fill_eff + KW'(1);
    end
  end

  assign new_entry.idx   = IDX_W'(pos_r);
  assign new_entry.score = in_ch.score;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (in_accept && in_ch.final_item && (fill_after != '0)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_accept && (filled_r == KW'(1))) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // FSM outputs.
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    unique case (state_r)
      ST_COLLECT: in_ch.ready  = 1'b1;
      ST_EMIT:    out_ch.valid = 1'b1;
      default: begin
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
      end
    endcase
  end

  assign ctrl.load = in_accept && rank_ok;
  assign ctrl.pop  = out_accept;

  // During emission the fill count doubles as the count of results left.
  // Past the candidate limit the fill count is left alone until the final request.
  always_comb begin
    filled_nxt = filled_r;
    pos_nxt    = pos_r;
    if (in_accept) begin
      if (rank_ok || in_ch.final_item) begin
        filled_nxt = fill_after;
      end
      if (in_ch.final_item) begin
        pos_nxt = '0;
      end else if (rank_ok) begin
        pos_nxt = pos_r + PW'(1);
      end
    end else if (out_accept) begin
      filled_nxt = filled_r - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_COLLECT;
      filled_r <= '0;
      pos_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      filled_r <= filled_nxt;
      pos_r    <= pos_nxt;
    end
  end

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    assign occ[i] = fill_eff > KW'(i);
    if (i == 0) begin : g_head
      stk_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_entry (new_entry),
        .occ       (occ[i]),
        .prev_ge   (1'b1),
        .prev_entry(new_entry),
        .next_entry((MAX_KEEP > 1) ? ent[(MAX_KEEP > 1) ? 1 : 0] : ent[0]),
        .entry     (ent[i]),
        .ge        (ge[i])
      );
    end else if (i == MAX_KEEP - 1) begin : g_tail
      stk_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_entry (new_entry),
        .occ       (occ[i]),
        .prev_ge   (ge[i-1]),
        .prev_entry(ent[i-1]),
        .next_entry(ent[i]),
        .entry     (ent[i]),
        .ge        (ge[i])
      );
    end else begin : g_mid
      stk_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_entry (new_entry),
        .occ       (occ[i]),
        .prev_ge   (ge[i-1]),
        .prev_entry(ent[i-1]),
        .next_entry(ent[i+1]),
        .entry     (ent[i]),
        .ge        (ge[i])
      );
    end
  end

  assign out_ch.candidate_index = ent[0].idx;
  assign out_ch.ranked_score    = ent[0].score;
  assign out_ch.last_result     = filled_r == KW'(1);

`ifndef SYNTHESIS
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> filled_r != '0)
    else $error("emitting with no results left");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= KW'(MAX_KEEP))
    else $error("fill count beyond cell count");

  a_final_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_ch.final_item && fill_after != '0 |=> out_ch.valid)
    else $error("final request did not start result output");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_accept && out_ch.last_result |=> in_ch.ready && pos_r == '0 && filled_r == '0)
    else $error("stream not cleared after last result");
`endif

endmodule

`default_nettype wire

>>> tb/stk_rank_checker.sv
// ----------------------------------------------------------------------------
// Streaming top-k selector checker
// Watches the score, result and APB ports, keeps its own ranked list per
// stream, and compares each ranked result with the oldest one still due.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_rank_checker
  import stk_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_ready,
  input  wire logic signed [SCORE_W-1:0] in_score,
  input  wire logic                      in_final,
  input  wire logic                      out_valid,
  input  wire logic                      out_ready,
  input  wire logic [IDX_W-1:0]          out_index,
  input  wire logic signed [SCORE_W-1:0] out_score,
  input  wire logic                      out_last,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic                      pready,
  input  wire logic [CFG_AW-1:0]         paddr,
  input  wire logic [CFG_DW-1:0]         pwdata,
  output int                             outstanding,
  output int                             error_total,
  output int                             score_total,
  output int                             rank_total,
  output int                             stream_total
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_AW-1:0] KEEP_ADDR = {REG_KEEP_COUNT, 2'b00};

  typedef struct packed {
    stk_entry_t entry;
    logic       last;
  } ranked_result_t;

  stk_entry_t        board [MAX_KEEP_DEF];
  int                filled;
  int                position;
  logic [KEEP_W-1:0] keep_reg;
  ranked_result_t    ranks_due [$];
  int                errs;
  int                scores;
  int                ranks;
  int                streams;

  initial begin
    errs    = 0;
    scores  = 0;
    ranks   = 0;
    streams = 0;
  end

  function automatic int active_keep();
    int k;
    k = int'(keep_reg);
    if (k < 1) k = 1;
    if (k > MAX_KEEP_DEF) k = MAX_KEEP_DEF;
    return k;
  endfunction

  // Shift-insert into the ranked list; a full list only admits a score
  // strictly above its last entry, so ties keep the earlier index ahead.
  function automatic void admit_score(input logic signed [SCORE_W-1:0] s,
                                      input logic [IDX_W-1:0] idx);
    int k;
    int j;
    k = active_keep();
    if (filled > k) filled = k;
    if (filled == k && s <= board[k-1].score) return;
    if (filled < k) begin
      j = filled;
      filled++;
    end else begin
      j = k - 1;
    end
    while (j > 0 && s > board[j-1].score) begin
      board[j] = board[j-1];
      j--;
    end
    board[j].idx   = idx;
    board[j].score = s;
  endfunction

  function automatic void close_stream();
    int n;
    ranked_result_t r;
    n = filled;
    if (n > active_keep()) n = active_keep();
    for (int i = 0; i < n; i++) begin
      r.entry = board[i];
      r.last  = (i == n - 1);
      ranks_due.push_back(r);
    end
    filled   = 0;
    position = 0;
  endfunction

  always @(posedge clk) begin
    ranked_result_t due;
    if (!rst_n) begin
      filled   = 0;
      position = 0;
      keep_reg = KEEP_RESET;
      ranks_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == KEEP_ADDR) begin
        keep_reg = pwdata[KEEP_W-1:0];
      end
      if (out_valid && out_ready) begin
        ranks++;
        if (ranks_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected ranked result, index %0d score %0d", $time,
                   out_index, out_score);
        end else begin
          due = ranks_due.pop_front();
          if (out_index !== due.entry.idx) begin
            errs++;
            $display("%0t: candidate_index expected %0d, got %0d", $time,
                     due.entry.idx, out_index);
          end
          if (out_score !== due.entry.score) begin
            errs++;
            $display("%0t: ranked_score expected %0d, got %0d", $time,
                     due.entry.score, out_score);
          end
          if (out_last !== due.last) begin
            errs++;
            $display("%0t: last_result expected %0b, got %0b", $time,
                     due.last, out_last);
          end
        end
      end
      if (in_valid && in_ready) begin
        scores++;
        // Positions past the candidate limit are not ranked and saturate.
        if (position < MAX_CAND_DEF) begin
          admit_score(in_score, IDX_W'(position));
          position++;
        end
        if (in_final) begin
          close_stream();
          streams++;
        end
      end
    end
    outstanding  <= ranks_due.size();
    error_total  <= errs;
    score_total  <= scores;
    rank_total   <= ranks;
    stream_total <= streams;
  end

endmodule

`default_nettype wire

>>> tb/streaming_top_k_selector_test.sv
// ----------------------------------------------------------------------------
// Streaming top-k selector testbench
// Drives score streams and keep_count settings into the selector, with random
// gaps and result stalls, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module streaming_top_k_selector_test;

  timeunit 1ns;
  timeprecision 1ps;

  import stk_pkg::*;

  localparam logic [CFG_AW-1:0] KEEP_ADDR = {REG_KEEP_COUNT, 2'b00};
  localparam int RANDOM_ITEMS  = 50;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_STREAM   = MAX_KEEP_DEF + 2;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  wire  [CFG_DW-1:0] prdata;
  wire               pready;
  bit                steady;
  int                random_sent;
  int                outstanding;
  int                error_total;
  int                score_total;
  int                rank_total;
  int                stream_total;

  stk_in_if  in_ch ();
  stk_out_if out_ch ();

  streaming_top_k_selector dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  stk_rank_checker ranks (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_score     (in_ch.score),
    .in_final     (in_ch.final_item),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_index    (out_ch.candidate_index),
    .out_score    (out_ch.ranked_score),
    .out_last     (out_ch.last_result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .outstanding  (outstanding),
    .error_total  (error_total),
    .score_total  (score_total),
    .rank_total   (rank_total),
    .stream_total (stream_total)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: stalls about a quarter of the cycles unless a steady stretch
  // is running.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= 25);
    end
  end

  function automatic logic signed [SCORE_W-1:0] pick_score();
    int v;
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        v = $urandom_range(8);
        return v - 4;
      end
      2: begin
        v = $urandom_range(15);
        return (v - 8) * 65536;
      end
      default: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          default: return 32'shFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [KEEP_W-1:0] pick_keep();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return KEEP_W'(1);
      3: return KEEP_W'(MAX_KEEP_DEF);
      4: return KEEP_W'($urandom);
      default: return KEEP_W'($urandom_range(MAX_KEEP_DEF, 1));
    endcase
  endfunction

  // Valid stays high between back-to-back requests; it only drops for a gap.
  task automatic send_score(input logic signed [SCORE_W-1:0] s, input logic fin);
    if (!steady && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 25);
    end
    in_ch.valid      <= 1'b1;
    in_ch.score      <= s;
    in_ch.final_item <= fin;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drain: stop requests, wait for every due result, then let the chain quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] k);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KEEP_ADDR;
    pwdata  <= CFG_DW'(k);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int len;
    int cut;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.score      <= '0;
    in_ch.final_item <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    steady            = 1'b0;
    random_sent       = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset keep count: extremes of the score range and a run of equal scores.
    send_score(32'sh0000_0000, 1'b0);
    send_score(32'sh7FFF_FFFF, 1'b0);
    send_score(32'sh8000_0000, 1'b0);
    send_score(32'shFFFF_FFFF, 1'b0);
    send_score(32'sh0000_0001, 1'b0);
    send_score(32'sh0005_0000, 1'b0);
    send_score(32'sh0001_8000, 1'b0);
    send_score(32'sh0005_0000, 1'b0);
    send_score(32'sh0005_0000, 1'b1);
    settle();

    // A keep count of zero behaves as one; the earlier of two ties wins.
    write_keep('0);
    send_score(32'sh0000_0003, 1'b0);
    send_score(32'sh0000_0007, 1'b0);
    send_score(32'sh0000_0007, 1'b0);
    send_score(-32'sh0000_0002, 1'b1);
    settle();

    // Keep count lowered in the middle of a stream.
    write_keep(KEEP_W'(5));
    send_score(32'sh0000_000A, 1'b0);
    send_score(-32'sh0000_000A, 1'b0);
    send_score(32'sh0000_0014, 1'b0);
    send_score(32'sh0000_001E, 1'b0);
    send_score(32'sh0000_0005, 1'b0);
    send_score(32'sh0000_0028, 1'b0);
    send_score(32'sh0000_0019, 1'b0);
    settle();
    write_keep(KEEP_W'(2));
    send_score(32'sh0000_0032, 1'b0);
    send_score(32'sh0000_0001, 1'b1);
    settle();
    send_score(32'sh8000_0000, 1'b1);
    settle();

    // Keep count above the maximum, with more scores than the chain holds.
    write_keep('1);
    for (int i = 0; i < LONG_STREAM; i++) send_score(pick_score(), i == LONG_STREAM - 1);
    settle();

    write_keep(KEEP_W'(1));
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(1) == 0) begin
        settle();
        write_keep(pick_keep());
      end
      len = $urandom_range(24, 1);
      cut = ($urandom_range(7) == 0) ? $urandom_range(len - 1) : -1;
      for (int i = 0; i < len; i++) begin
        steady = (random_sent >= 10) && (random_sent < 40);
        if (i == cut && i > 0) begin
          settle();
          write_keep(pick_keep());
        end
        send_score(pick_score(), i == len - 1);
        random_sent++;
      end
    end
    steady = 1'b0;
    settle();

    $display("Covered %0d score requests in %0d streams and checked %0d ranked results,",
             score_total, stream_total, rank_total);
    $display("with keep counts from zero to the register maximum and a stalls-free stretch.");
    if (error_total == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/stk_pkg.sv
design/stk_ifaces.sv
design/stk_cfg_regs.sv
design/stk_cell.sv
design/streaming_top_k_selector.sv
tb/stk_rank_checker.sv
tb/streaming_top_k_selector_test.sv
